// ===== hw/rtl/sgb_pkg.sv =====
// Shared constants and types for the separable Gaussian blur.
// Used by every module of the block but sgb_ram; depends on nothing.
package sgb_pkg;

  localparam int DEF_MAX_RADIUS = 3;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 16;
  localparam int COEF_W     = 17;
  localparam int NUM_COEF   = 4;
  localparam int DIM_W      = 11;
  localparam int RAD_W      = 2;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;

  localparam logic [DIM_W-1:0]  RST_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0]  RST_HEIGHT = 11'd480;
  localparam logic [RAD_W-1:0]  RST_RADIUS = 2'd2;
  localparam logic [COEF_W-1:0] RST_COEF0  = 17'd26386;
  localparam logic [COEF_W-1:0] RST_COEF1  = 17'd16004;
  localparam logic [COEF_W-1:0] RST_COEF2  = 17'd3571;
  localparam logic [COEF_W-1:0] RST_COEF3  = 17'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_RADIUS = 3'd2,
    REG_COEF0  = 3'd3,
    REG_COEF1  = 3'd4,
    REG_COEF2  = 3'd5,
    REG_COEF3  = 3'd6
  } sgb_reg_t;

  typedef logic [NUM_COEF-1:0][COEF_W-1:0] sgb_coef_t;

  typedef struct packed {
    logic frame_end;
    logic run_last;
  } sgb_tag_t;

endpackage

// ===== hw/rtl/sgb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Read-first on a collision. No dependencies.
module sgb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/sgb_row_filter.sv =====
// Horizontal filter: one row sum in Q8.8 from the pixel window.
// Depends on sgb_pkg.
module sgb_row_filter
  import sgb_pkg::*;
#(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
  input  logic [2*MAX_RADIUS:0][PIX_W-1:0]   window,
  input  logic [$clog2(MAX_WIDTH)-1:0]       col,
  input  logic [$clog2(MAX_WIDTH)-1:0]       x,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]    radius,
  input  sgb_coef_t                          coef,
  input  logic                               drain,
  output logic [SUM_W-1:0]                   h
);

  localparam int TAPS = 2 * MAX_RADIUS + 1;
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int IW   = $clog2(TAPS);
  localparam int RADW = $clog2(MAX_RADIUS + 1);
  localparam int PW   = PIX_W + COEF_W;
  localparam int RSW  = PW + $clog2(TAPS) + 1;

  logic [TAPS-1:0][PW-1:0] prod;
  logic [RSW-1:0]          sum;
  logic [RSW-1:0]          rnd;

  for (genvar t = 0; t < TAPS; t++) begin : g_tap
    localparam int K = t - MAX_RADIUS;
    localparam int D = (K < 0) ? -K : K;
    logic [COEF_W-1:0]    w;
    logic signed [XW+1:0] j;
    logic [XW+1:0]        idx;
    logic [PIX_W-1:0]     pix;

    if (D < NUM_COEF) begin : g_w
      assign w = coef[D];
    end else begin : g_z
      assign w = '0;
    end

    // Clamp the tap column to the row, then find its age in the window.
    always_comb begin
      j = $signed({2'b00, x}) + (XW+2)'(K);
      if (j < 0) begin
        j = '0;
      end
      if (j > $signed({2'b00, col})) begin
        j = $signed({2'b00, col});
      end
      idx = {2'b00, col} - $unsigned(j);
      if (idx > (XW+2)'(TAPS - 1)) begin
        idx = (XW+2)'(TAPS - 1);
      end
      pix = window[idx[IW-1:0]];
      prod[t] = (radius >= RADW'(D)) ? PW'(pix * w) : '0;
    end
  end

  always_comb begin
    sum = '0;
    for (int t = 0; t < TAPS; t++) begin
      sum = sum + RSW'(prod[t]);
    end
    rnd = sum + RSW'(128);
    if (drain) begin
      h = '0;
    end else if (rnd[RSW-1:8] > (RSW-8)'(16'hFFFF)) begin
      h = '1;
    end else begin
      h = rnd[SUM_W+7:8];
    end
  end

endmodule

// ===== hw/rtl/sgb_col_filter.sv =====
// Vertical filter: tap select, products, sum and the output register.
// Depends on sgb_pkg.
module sgb_col_filter
  import sgb_pkg::*;
#(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          en,
  input  logic                                          load,
  input  logic [SUM_W-1:0]                              h_in,
  input  logic [2*MAX_RADIUS:0]                         use_h,
  input  logic [2*MAX_RADIUS:0][$clog2(2*MAX_RADIUS)-1:0] slot,
  input  sgb_tag_t                                      tag_in,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]               radius,
  input  sgb_coef_t                                     coef,
  input  logic [2*MAX_RADIUS-1:0][SUM_W-1:0]            ram_q,
  output logic                                          out_valid,
  output logic [SUM_W-1:0]                              blurred,
  output sgb_tag_t                                      tag_out
);

  localparam int TAPS = 2 * MAX_RADIUS + 1;
  localparam int SLW  = $clog2(2 * MAX_RADIUS);
  localparam int RADW = $clog2(MAX_RADIUS + 1);
  localparam int PW   = SUM_W + COEF_W;
  localparam int CSW  = PW + $clog2(TAPS) + 1;

  logic                          s1_valid;
  logic [SUM_W-1:0]              s1_h;
  logic [TAPS-1:0]               s1_use_h;
  logic [TAPS-1:0][SLW-1:0]      s1_slot;
  sgb_tag_t                      s1_tag;
  logic [TAPS-1:0][PW-1:0]       prod;
  logic                          s2_valid;
  logic [TAPS-1:0][PW-1:0]       s2_prod;
  sgb_tag_t                      s2_tag;
  logic [CSW-1:0]                sum;
  logic [CSW-1:0]                rnd;
  logic [SUM_W-1:0]              res;

  for (genvar t = 0; t < TAPS; t++) begin : g_tap
    localparam int K = t - MAX_RADIUS;
    localparam int D = (K < 0) ? -K : K;
    logic [COEF_W-1:0] w;
    logic [SUM_W-1:0]  v;

    if (D < NUM_COEF) begin : g_w
      assign w = coef[D];
    end else begin : g_z
      assign w = '0;
    end

    assign v       = s1_use_h[t] ? s1_h : ram_q[s1_slot[t]];
    assign prod[t] = (radius >= RADW'(D)) ? PW'(v * w) : '0;
  end

  always_comb begin
    sum = '0;
    for (int t = 0; t < TAPS; t++) begin
      sum = sum + CSW'(s2_prod[t]);
    end
    rnd = sum + CSW'(32768);
    if (rnd[CSW-1:16] > (CSW-16)'(16'hFFFF)) begin
      res = '1;
    end else begin
      res = rnd[SUM_W+15:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= load;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_h     <= h_in;
      s1_use_h <= use_h;
      s1_slot  <= slot;
      s1_tag   <= tag_in;
      s2_prod  <= prod;
      s2_tag   <= s1_tag;
      blurred  <= res;
      tag_out  <= s2_tag;
    end
  end

endmodule

// ===== hw/rtl/separable_gaussian_blur.sv =====
// Separable Gaussian blur with edge clamping: window, counters, line stores and sequencing.
// Depends on sgb_pkg, sgb_ram, sgb_row_filter and sgb_col_filter.
//
// Grey pixels arrive in raster order; each result is a Q8.8 blurred pixel, lagging the
// input by radius rows, and radius rows of drain beats after the frame flush the rest. An
// input beat is taken every cycle while the output is not stalled, except at the last column
// of a row, where the column sequencer emits one finished column per cycle, stalls aside: that
// beat emits radius+1 columns (fewer when the row is narrower than that) before the next is
// taken. A result passes the sequencer register, line store read, column products and output
// register after its beat is taken; a stall on the output holds the whole pipeline.
// Row sums live in 2*MAX_RADIUS line stores of MAX_WIDTH entries; no clearing pass is run.
module separable_gaussian_blur
  import sgb_pkg::*;
#(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic [PIX_W-1:0]      pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SUM_W-1:0]      blurred,
  output logic                  frame_end,
  output logic                  run_last
);

  localparam int TAPS = 2 * MAX_RADIUS + 1;
  localparam int RING = 2 * MAX_RADIUS;
  localparam int SLW  = $clog2(RING);
  localparam int SX   = $clog2(2 * RING + 1);
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
  localparam int RADW = $clog2(MAX_RADIUS + 1);

  // Configuration registers.
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [RAD_W-1:0] kernel_radius;
  sgb_coef_t        coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= RST_WIDTH;
      image_height  <= RST_HEIGHT;
      kernel_radius <= RST_RADIUS;
      coef          <= {RST_COEF3, RST_COEF2, RST_COEF1, RST_COEF0};
    end else if (cfg_write_en) begin
      case (sgb_reg_t'(cfg_index))
        REG_WIDTH:  image_width   <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: image_height  <= cfg_data[DIM_W-1:0];
        REG_RADIUS: kernel_radius <= cfg_data[RAD_W-1:0];
        REG_COEF0:  coef[0]       <= cfg_data[COEF_W-1:0];
        REG_COEF1:  coef[1]       <= cfg_data[COEF_W-1:0];
        REG_COEF2:  coef[2]       <= cfg_data[COEF_W-1:0];
        REG_COEF3:  coef[3]       <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame geometry.
  logic [WW-1:0]   eff_w;
  logic [WW-1:0]   w_m1;
  logic [XW-1:0]   w_last;
  logic [RW-1:0]   eff_h;
  logic [RW-1:0]   h_last;
  logic [RADW-1:0] eff_r;
  logic [RW-1:0]   last_row;

  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = RW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(image_height);
    end
    if (32'(kernel_radius) > MAX_RADIUS) begin
      eff_r = RADW'(MAX_RADIUS);
    end else begin
      eff_r = RADW'(kernel_radius);
    end
    w_m1     = eff_w - WW'(1);
    w_last   = w_m1[XW-1:0];
    h_last   = eff_h - RW'(1);
    last_row = eff_h + RW'(eff_r) - RW'(1);
  end

  // Frame position, ring slot of the current row and the pixel window.
  logic [XW-1:0]             column_count, column_count_next;
  logic [RW-1:0]             row_count, row_count_next;
  logic [SLW-1:0]            slot_count, slot_count_next;
  logic [TAPS-1:0][PIX_W-1:0] window;

  // Column sequencer registers.
  logic           s0_valid;
  logic           s0_drain;
  logic [XW-1:0]  s0_c;
  logic [XW-1:0]  s0_x;
  logic [XW-1:0]  s0_x1;
  logic [RW-1:0]  s0_r;
  logic [RW-1:0]  s0_y;
  logic [SLW-1:0] s0_slot;
  logic           s0_emit;
  logic           s0_last;

  logic          en;
  logic          take;
  logic          act;
  logic [XW-1:0] c;
  logic [RW-1:0] r;
  logic [XW-1:0] rx;
  logic          ignore;
  logic          last_col;
  logic          has_x;
  logic [XW-1:0] x0;
  logic [XW-1:0] x1;

  assign en       = !out_valid || out_ready;
  assign s0_last  = (s0_x == s0_x1);
  assign in_ready = en && (!s0_valid || s0_last);
  assign take     = in_valid && in_ready;
  assign act      = take && !ignore;

  always_comb begin
    c        = (column_count < w_last) ? column_count : w_last;
    r        = (row_count < last_row) ? row_count : last_row;
    rx       = XW'(eff_r);
    ignore   = (!operation && r >= eff_h) || (operation && r < eff_h);
    last_col = (c == w_last);
    has_x    = last_col || (c >= rx);
    x1       = last_col ? c : c - rx;
    x0       = (c >= rx) ? c - rx : '0;

    column_count_next = column_count;
    row_count_next    = row_count;
    slot_count_next   = slot_count;
    if (act) begin
      if (last_col) begin
        column_count_next = '0;
        if (r >= last_row) begin
          row_count_next  = '0;
          slot_count_next = '0;
        end else begin
          row_count_next  = r + RW'(1);
          slot_count_next = (slot_count == SLW'(RING - 1)) ? '0 : slot_count + SLW'(1);
        end
      end else begin
        column_count_next = c + XW'(1);
        row_count_next    = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      slot_count   <= '0;
      window       <= '0;
      s0_valid     <= 1'b0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      slot_count   <= slot_count_next;
      if (act && !operation) begin
        window <= {window[TAPS-2:0], pixel};
      end
      if (en) begin
        if (s0_valid && !s0_last) begin
          s0_valid <= 1'b1;
        end else begin
          s0_valid <= act && has_x;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s0_valid && !s0_last) begin
        s0_x <= s0_x + XW'(1);
      end else if (act) begin
        s0_drain <= operation;
        s0_c     <= c;
        s0_x     <= x0;
        s0_x1    <= x1;
        s0_r     <= r;
        s0_y     <= r - RW'(eff_r);
        s0_slot  <= slot_count;
        s0_emit  <= (r >= RW'(eff_r));
      end
    end
  end

  // Row sum of the column under the sequencer.
  logic [SUM_W-1:0] h;

  sgb_row_filter #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_row (
    .window (window),
    .col    (s0_c),
    .x      (s0_x),
    .radius (eff_r),
    .coef   (coef),
    .drain  (s0_drain),
    .h      (h)
  );

  // Which row each vertical tap takes, and where that row sits in the ring.
  logic [TAPS-1:0]          use_h;
  logic [TAPS-1:0][SLW-1:0] slot;

  for (genvar t = 0; t < TAPS; t++) begin : g_tap
    localparam int K = t - MAX_RADIUS;
    logic signed [RW+1:0] rr;
    logic [RW+1:0]        d;
    logic [SX-1:0]        dd;
    logic [SX-1:0]        sel;

    always_comb begin
      rr = $signed({2'b00, s0_y}) + (RW+2)'(K);
      if (rr < 0) begin
        rr = '0;
      end
      if (rr > $signed({2'b00, h_last})) begin
        rr = $signed({2'b00, h_last});
      end
      use_h[t] = !s0_drain && ($unsigned(rr) == {2'b00, s0_r});
      d        = {2'b00, s0_r} - $unsigned(rr);
      // Taps outside the radius carry no weight; keep their slot in range.
      dd       = (d > (RW+2)'(RING)) ? '0 : SX'(d);
      if (SX'(s0_slot) >= dd) begin
        sel = SX'(s0_slot) - dd;
      end else begin
        sel = SX'(s0_slot) + SX'(RING) - dd;
      end
      slot[t] = sel[SLW-1:0];
    end
  end

  // Line stores, one per ring row, all read at the sequencer's column.
  logic [RING-1:0][SUM_W-1:0] ram_q;

  for (genvar g = 0; g < RING; g++) begin : g_store
    sgb_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_WIDTH)
    ) u_store (
      .clk   (clk),
      .we    (en && s0_valid && !s0_drain && (s0_slot == SLW'(g))),
      .waddr (s0_x),
      .wdata (h),
      .re    (en),
      .raddr (s0_x),
      .rdata (ram_q[g])
    );
  end

  sgb_tag_t tag_in;
  sgb_tag_t tag_out;

  assign tag_in.frame_end = (s0_y == h_last) && (s0_x == w_last);
  assign tag_in.run_last  = s0_last;

  sgb_col_filter #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_col (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .load      (s0_valid && s0_emit),
    .h_in      (h),
    .use_h     (use_h),
    .slot      (slot),
    .tag_in    (tag_in),
    .radius    (eff_r),
    .coef      (coef),
    .ram_q     (ram_q),
    .out_valid (out_valid),
    .blurred   (blurred),
    .tag_out   (tag_out)
  );

  assign frame_end = tag_out.frame_end;
  assign run_last  = tag_out.run_last;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input beat taken while the output is stalled");

  a_seq_in_range: assert property (@(posedge clk) disable iff (rst)
    s0_valid |-> (s0_x <= s0_x1))
    else $error("column sequencer ran past its last column");

  a_window_shift: assert property (@(posedge clk) disable iff (rst)
    (act && !operation) |=> (window[0] == $past(pixel)))
    else $error("pixel window did not take the accepted pixel");
`endif

endmodule
